// File: sv/lmbs_pkg.sv
`timescale 1ns / 1ps
package lmbs_pkg;

	// frame and panel geometry
	localparam int FRAME_WIDTH  = 64;
	localparam int FRAME_HEIGHT = 64;
	localparam int TILE_HEIGHT  = 32;
	localparam int TILE_WIDTH   = 64;
	localparam int TILE_COUNT   = 2;
	localparam int PLANE_COUNT  = 8;

	localparam int STORE_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int HALF_TILE   = TILE_HEIGHT / 2;

	// field and counter widths
	localparam int ADDR_W     = 12;
	localparam int PIXEL_W    = 24;
	localparam int CHAN_W     = 8;
	localparam int ROW_W      = 4;
	localparam int PLANE_W    = 3;
	localparam int PANEL_W    = 1;
	localparam int COL_W      = 6;
	localparam int XIDX_W     = $clog2(FRAME_WIDTH);
	localparam int YIDX_W     = $clog2(FRAME_HEIGHT);
	localparam int BASE_W     = 16;
	localparam int ON_TIME_W  = 23;
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	localparam logic [BASE_W-1:0] ON_TIME_BASE_RESET = 16'd100;

	// register index taken from paddr[2]
	localparam logic REG_ON_TIME_BASE = 1'b0;

	// opcodes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// scan phases and event kinds share one encoding
	localparam logic [1:0] KIND_PIXEL = 2'd0;
	localparam logic [1:0] KIND_PAD   = 2'd1;
	localparam logic [1:0] KIND_LATCH = 2'd2;

	typedef struct packed {
		logic                 opcode;
		logic [ADDR_W-1:0]    pixel_index;
		logic [PIXEL_W-1:0]   pixel_rgb;
	} in_item_t;

	typedef struct packed {
		logic [1:0]           event_kind;
		logic [2:0]           upper_bits;
		logic [2:0]           lower_bits;
		logic [ROW_W-1:0]     row_select;
		logic [ON_TIME_W-1:0] on_time;
		logic                 frame_done;
	} out_item_t;

	typedef struct packed {
		logic wr_capture;
		logic wr_commit;
		logic tick_capture;
		logic tick_emit;
	} ctrl_cmd_t;

endpackage

// File: sv/lmbs_ram.sv
`timescale 1ns / 1ps
module lmbs_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

// File: sv/lmbs_ctrl.sv
`timescale 1ns / 1ps
module lmbs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                opcode,
	output logic                busy,
	output lmbs_pkg::ctrl_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WRITE = 2'd1;
	localparam logic [1:0] ST_EMIT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       accept;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	// commands to the datapath
	always_comb begin
		cmd.wr_capture   = accept && (opcode == lmbs_pkg::OP_WRITE);
		cmd.tick_capture = accept && (opcode == lmbs_pkg::OP_TICK);
		cmd.wr_commit    = (state_q == ST_WRITE);
		cmd.tick_emit    = (state_q == ST_EMIT);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (opcode == lmbs_pkg::OP_WRITE) ? ST_WRITE : ST_EMIT;
				end
			end
			ST_WRITE: state_d = ST_IDLE;
			ST_EMIT:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: sv/lmbs_dpath.sv
`timescale 1ns / 1ps
module lmbs_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lmbs_pkg::ctrl_cmd_t               cmd,
	input  lmbs_pkg::in_item_t                request,
	input  logic [lmbs_pkg::BASE_W-1:0]       on_time_base,
	output logic                              result_strobe,
	output lmbs_pkg::out_item_t               result
);

	localparam int ADDR_W = lmbs_pkg::ADDR_W;
	localparam int CW     = lmbs_pkg::CHAN_W;

	// squaring gamma divide: x / 255 for any x up to 255 * 255
	function automatic logic [CW-1:0] div255(input logic [2*CW-1:0] x);
		logic [2*CW:0] t;
		t = {1'b0, x} + {{(CW+1){1'b0}}, x[2*CW-1:CW]} + {{(2*CW){1'b0}}, 1'b1};
		return t[2*CW-1:CW];
	endfunction

	// bit plane of one pixel: bit0 red, bit1 green, bit2 blue
	function automatic logic [2:0] plane_bits(input logic [lmbs_pkg::PIXEL_W-1:0] pix,
						  input logic [lmbs_pkg::PLANE_W-1:0] s);
		logic r, g, b;
		r = pix[2*CW + 32'(s)];
		g = pix[CW + 32'(s)];
		b = pix[32'(s)];
		return {b, g, r};
	endfunction

	// write path registers
	logic [2*CW-1:0]   sq_r_s1, sq_g_s1, sq_b_s1;
	logic [ADDR_W-1:0] waddr_s1;
	logic [lmbs_pkg::PIXEL_W-1:0] wdata;

	// scan counters
	logic [lmbs_pkg::ROW_W-1:0]   row_q;
	logic [lmbs_pkg::PLANE_W-1:0] plane_q;
	logic [lmbs_pkg::PANEL_W-1:0] panel_q;
	logic [lmbs_pkg::COL_W-1:0]   col_q;
	logic [1:0]                   phase_q;

	// tick snapshot
	logic [1:0]                     kind_s1;
	logic [lmbs_pkg::PLANE_W-1:0]   plane_s1;
	logic [lmbs_pkg::ROW_W-1:0]     row_s1;
	logic [lmbs_pkg::ON_TIME_W-1:0] on_time_s1;
	logic                           done_s1;

	// store addresses
	logic [lmbs_pkg::YIDX_W-1:0] irow;
	logic [lmbs_pkg::XIDX_W-1:0] c1, c2;
	logic [ADDR_W-1:0]           raddr_a, raddr_b;
	logic [lmbs_pkg::PIXEL_W-1:0] rdata_a, rdata_b;

	// squares of the raw channels at accept
	always_ff @(posedge clk) begin
		if (cmd.wr_capture) begin
			sq_r_s1  <= request.pixel_rgb[3*CW-1:2*CW] * request.pixel_rgb[3*CW-1:2*CW];
			sq_g_s1  <= request.pixel_rgb[2*CW-1:CW] * request.pixel_rgb[2*CW-1:CW];
			sq_b_s1  <= request.pixel_rgb[CW-1:0] * request.pixel_rgb[CW-1:0];
			waddr_s1 <= ADDR_W'(32'(request.pixel_index) % lmbs_pkg::STORE_DEPTH);
		end
	end

	assign wdata = {div255(sq_r_s1), div255(sq_g_s1), div255(sq_b_s1)};

	// rotated panel mapping
	always_comb begin
		if (panel_q[0]) begin
			irow = lmbs_pkg::YIDX_W'(col_q);
			c1   = lmbs_pkg::XIDX_W'((32'(panel_q) + 32'd1) * lmbs_pkg::TILE_HEIGHT
				- 32'd1 - 32'(row_q));
			c2   = lmbs_pkg::XIDX_W'(32'(c1) - lmbs_pkg::HALF_TILE);
		end else begin
			irow = lmbs_pkg::YIDX_W'(lmbs_pkg::FRAME_HEIGHT - 32'd1 - 32'(col_q));
			c1   = lmbs_pkg::XIDX_W'(32'(panel_q) * lmbs_pkg::TILE_HEIGHT + 32'(row_q));
			c2   = lmbs_pkg::XIDX_W'(32'(c1) + lmbs_pkg::HALF_TILE);
		end
		raddr_a = ADDR_W'((32'(irow) * lmbs_pkg::FRAME_WIDTH + 32'(c1))
			% lmbs_pkg::STORE_DEPTH);
		raddr_b = ADDR_W'((32'(irow) * lmbs_pkg::FRAME_WIDTH + 32'(c2))
			% lmbs_pkg::STORE_DEPTH);
	end

	lmbs_ram #(
		.WIDTH(lmbs_pkg::PIXEL_W),
		.DEPTH(lmbs_pkg::STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.we     (cmd.wr_commit),
		.waddr  (waddr_s1),
		.wdata  (wdata),
		.re     (cmd.tick_capture),
		.raddr_a(raddr_a),
		.raddr_b(raddr_b),
		.rdata_a(rdata_a),
		.rdata_b(rdata_b)
	);

	// snapshot of the event fields at a tick
	always_ff @(posedge clk) begin
		if (cmd.tick_capture) begin
			kind_s1    <= (phase_q == lmbs_pkg::KIND_PIXEL || phase_q == lmbs_pkg::KIND_PAD)
				? phase_q : lmbs_pkg::KIND_LATCH;
			plane_s1   <= plane_q;
			row_s1     <= row_q;
			on_time_s1 <= lmbs_pkg::ON_TIME_W'(on_time_base) << plane_q;
			done_s1    <= (plane_q == lmbs_pkg::PLANE_W'(lmbs_pkg::PLANE_COUNT - 1))
				&& (row_q == lmbs_pkg::ROW_W'(lmbs_pkg::HALF_TILE - 1));
		end
	end

	// scan counter advance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			plane_q <= '0;
			panel_q <= '0;
			col_q   <= '0;
			phase_q <= lmbs_pkg::KIND_PIXEL;
		end else if (cmd.tick_capture) begin
			case (phase_q)
				lmbs_pkg::KIND_PIXEL: begin
					if (col_q == lmbs_pkg::COL_W'(lmbs_pkg::TILE_WIDTH - 1)) begin
						col_q <= '0;
						if (panel_q == lmbs_pkg::PANEL_W'(lmbs_pkg::TILE_COUNT - 1)) begin
							panel_q <= '0;
							phase_q <= lmbs_pkg::KIND_PAD;
						end else begin
							panel_q <= panel_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				lmbs_pkg::KIND_PAD: begin
					phase_q <= lmbs_pkg::KIND_LATCH;
				end
				default: begin
					phase_q <= lmbs_pkg::KIND_PIXEL;
					if (plane_q == lmbs_pkg::PLANE_W'(lmbs_pkg::PLANE_COUNT - 1)) begin
						plane_q <= '0;
						if (row_q == lmbs_pkg::ROW_W'(lmbs_pkg::HALF_TILE - 1)) begin
							row_q <= '0;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						plane_q <= plane_q + 1'b1;
					end
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.tick_emit) begin
			result.event_kind <= kind_s1;
			result.upper_bits <= (kind_s1 == lmbs_pkg::KIND_PIXEL)
				? plane_bits(rdata_a, plane_s1) : 3'd0;
			result.lower_bits <= (kind_s1 == lmbs_pkg::KIND_PIXEL)
				? plane_bits(rdata_b, plane_s1) : 3'd0;
			result.row_select <= (kind_s1 == lmbs_pkg::KIND_LATCH) ? row_s1 : '0;
			result.on_time    <= (kind_s1 == lmbs_pkg::KIND_LATCH) ? on_time_s1 : '0;
			result.frame_done <= (kind_s1 == lmbs_pkg::KIND_LATCH) && done_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_strobe <= 1'b0;
		end else begin
			result_strobe <= cmd.tick_emit;
		end
	end

endmodule

// File: sv/led_matrix_bitplane_scanner_top.sv
`timescale 1ns / 1ps
// channel   signals                               handshake
// request   start, busy, request                  taken when start && !busy
// result    result_strobe, result                 one cycle per item, no stall
// config    psel, penable, pwrite, paddr, pwdata  written in access phase, pready tied high
//
// a write item holds busy for one cycle after accept: squares are registered,
// then divided and stored. a tick item holds busy for one cycle as well; its
// result is registered from the snapshot and the registered two-port frame
// store read. a new item is taken only once busy drops. reset clears the scan
// counters and loads the base register with its reset value; the frame store is not cleared.
module led_matrix_bitplane_scanner_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  lmbs_pkg::in_item_t                request,
	output logic                              result_strobe,
	output lmbs_pkg::out_item_t               result,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [lmbs_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [lmbs_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [lmbs_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready
);

	lmbs_pkg::ctrl_cmd_t             cmd;
	logic [lmbs_pkg::BASE_W-1:0]     on_time_base_q;
	logic                            cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	// on-time base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			on_time_base_q <= lmbs_pkg::ON_TIME_BASE_RESET;
		end else if (cfg_write && (paddr[2] == lmbs_pkg::REG_ON_TIME_BASE)) begin
			on_time_base_q <= pwdata[lmbs_pkg::BASE_W-1:0];
		end
	end

	// register readback
	always_comb begin
		if (paddr[2] == lmbs_pkg::REG_ON_TIME_BASE) begin
			prdata = lmbs_pkg::APB_DATA_W'(on_time_base_q);
		end else begin
			prdata = '0;
		end
	end

	lmbs_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.opcode(request.opcode),
		.busy  (busy),
		.cmd   (cmd)
	);

	lmbs_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.request      (request),
		.on_time_base (on_time_base_q),
		.result_strobe(result_strobe),
		.result       (result)
	);

endmodule

// File: tb/led_matrix_bitplane_scanner_top_tb.sv
`timescale 1ns / 1ps
module led_matrix_bitplane_scanner_top_tb;

	localparam int ADDR_W       = lmbs_pkg::ADDR_W;
	localparam int PIXEL_W      = lmbs_pkg::PIXEL_W;
	localparam int CHAN_W       = lmbs_pkg::CHAN_W;
	localparam int ROW_W        = lmbs_pkg::ROW_W;
	localparam int PLANE_W      = lmbs_pkg::PLANE_W;
	localparam int PANEL_W      = lmbs_pkg::PANEL_W;
	localparam int COL_W        = lmbs_pkg::COL_W;
	localparam int XIDX_W       = lmbs_pkg::XIDX_W;
	localparam int YIDX_W       = lmbs_pkg::YIDX_W;
	localparam int BASE_W       = lmbs_pkg::BASE_W;
	localparam int ON_TIME_W    = lmbs_pkg::ON_TIME_W;
	localparam int APB_ADDR_W   = lmbs_pkg::APB_ADDR_W;
	localparam int APB_DATA_W   = lmbs_pkg::APB_DATA_W;
	localparam int STORE_DEPTH  = lmbs_pkg::STORE_DEPTH;
	localparam int HALF_TILE    = lmbs_pkg::HALF_TILE;
	localparam int FRAME_WIDTH  = lmbs_pkg::FRAME_WIDTH;
	localparam int FRAME_HEIGHT = lmbs_pkg::FRAME_HEIGHT;
	localparam int TILE_HEIGHT  = lmbs_pkg::TILE_HEIGHT;
	localparam int TILE_WIDTH   = lmbs_pkg::TILE_WIDTH;
	localparam int TILE_COUNT   = lmbs_pkg::TILE_COUNT;
	localparam int PLANE_COUNT  = lmbs_pkg::PLANE_COUNT;

	localparam logic       OP_WRITE   = lmbs_pkg::OP_WRITE;
	localparam logic       OP_TICK    = lmbs_pkg::OP_TICK;
	localparam logic [1:0] KIND_PIXEL = lmbs_pkg::KIND_PIXEL;
	localparam logic [1:0] KIND_PAD   = lmbs_pkg::KIND_PAD;
	localparam logic [1:0] KIND_LATCH = lmbs_pkg::KIND_LATCH;

	localparam int PHASE_COUNT   = 5;
	// 5 early ticks plus these end on the last latch of row pair zero
	localparam int PHASE_TICKS   = 207;
	localparam int HOLD_EVERY    = 50;
	localparam int SETTLE_CYCLES = 12;
	localparam int DRAIN_LIMIT   = 2000;
	localparam int IDLE_PCT [PHASE_COUNT] = '{0, 83, 30, 0, 30};
	// image columns read by row pair zero on both panels
	localparam int SCAN_COLS [4] = '{0, HALF_TILE, 2 * TILE_HEIGHT - 1 - HALF_TILE,
		2 * TILE_HEIGHT - 1};

	localparam logic [APB_ADDR_W-1:0] ADDR_BASE     = {lmbs_pkg::REG_ON_TIME_BASE, 2'b00};
	localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = {~lmbs_pkg::REG_ON_TIME_BASE, 2'b00};

	typedef struct {
		lmbs_pkg::in_item_t cmd;
		bit                 hold;
	} queued_cmd_t;

	logic                  clk     = 1'b0;
	logic                  arst_n  = 1'b0;
	logic                  start   = 1'b0;
	lmbs_pkg::in_item_t    request = '0;
	logic                  psel    = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite  = 1'b0;
	logic [APB_ADDR_W-1:0] paddr   = '0;
	logic [APB_DATA_W-1:0] pwdata  = '0;
	logic                  busy;
	logic                  result_strobe;
	lmbs_pkg::out_item_t   result;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	queued_cmd_t         cmd_queue[$];
	lmbs_pkg::out_item_t expected_events[$];
	int                  errors          = 0;
	int                  events_checked  = 0;
	int                  sender_idle_pct = 0;

	// scan state mirrored from the block
	logic [PIXEL_W-1:0]   frame_copy [STORE_DEPTH];
	logic [ROW_W-1:0]     row_q   = '0;
	logic [PLANE_W-1:0]   plane_q = '0;
	logic [PANEL_W-1:0]   panel_q = '0;
	logic [COL_W-1:0]     col_q   = '0;
	logic [1:0]           phase_q = KIND_PIXEL;
	logic [BASE_W-1:0]    base_q  = lmbs_pkg::ON_TIME_BASE_RESET;

	led_matrix_bitplane_scanner_top uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.request      (request),
		.result_strobe(result_strobe),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(1_000_000);
		$display("FAILURE");
		$finish;
	end

	task automatic report_error(input string msg);
		$display("%0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want) begin
			report_error($sformatf("event %0d %s: got %0h, expected %0h",
				events_checked, name, got, want));
		end
	endtask

	// squaring gamma on one channel
	function automatic logic [CHAN_W-1:0] gamma_channel(input logic [CHAN_W-1:0] c);
		logic [2*CHAN_W-1:0] sq;
		sq = c * c;
		return CHAN_W'(sq / 16'd255);
	endfunction

	// bit plane of one pixel: red in bit 0, blue in bit 2
	function automatic logic [2:0] plane_slice(input logic [PIXEL_W-1:0] pix,
			input logic [PLANE_W-1:0] plane);
		return {pix[plane], pix[8 + plane], pix[16 + plane]};
	endfunction

	// apply one accepted item to the mirrored state, queue the event it causes
	function automatic void model_cmd(input lmbs_pkg::in_item_t cmd);
		lmbs_pkg::out_item_t   ev;
		logic [YIDX_W-1:0]     img_row;
		logic [XIDX_W-1:0]     col_a;
		logic [XIDX_W-1:0]     col_b;
		logic [ADDR_W-1:0]     idx_a;
		logic [ADDR_W-1:0]     idx_b;
		logic [ON_TIME_W-1:0]  ont;
		if (cmd.opcode == OP_WRITE) begin
			frame_copy[cmd.pixel_index] = {gamma_channel(cmd.pixel_rgb[23:16]),
				gamma_channel(cmd.pixel_rgb[15:8]), gamma_channel(cmd.pixel_rgb[7:0])};
			return;
		end
		ev = '0;
		case (phase_q)
			KIND_PIXEL: begin
				// odd panels mirror columns, even panels flip rows
				if (panel_q[0]) begin
					img_row = YIDX_W'(col_q);
					col_a = XIDX_W'((32'(panel_q) + 1) * TILE_HEIGHT - 1 - 32'(row_q));
					col_b = XIDX_W'(32'(col_a) - HALF_TILE);
				end else begin
					img_row = YIDX_W'(FRAME_HEIGHT - 1 - 32'(col_q));
					col_a = XIDX_W'(32'(panel_q) * TILE_HEIGHT + 32'(row_q));
					col_b = XIDX_W'(32'(col_a) + HALF_TILE);
				end
				idx_a = ADDR_W'(32'(img_row) * FRAME_WIDTH + 32'(col_a));
				idx_b = ADDR_W'(32'(img_row) * FRAME_WIDTH + 32'(col_b));
				ev.event_kind = KIND_PIXEL;
				ev.upper_bits = plane_slice(frame_copy[idx_a], plane_q);
				ev.lower_bits = plane_slice(frame_copy[idx_b], plane_q);
				if (col_q == COL_W'(TILE_WIDTH - 1)) begin
					col_q = '0;
					if (panel_q == PANEL_W'(TILE_COUNT - 1)) begin
						panel_q = '0;
						phase_q = KIND_PAD;
					end else begin
						panel_q = panel_q + 1'b1;
					end
				end else begin
					col_q = col_q + 1'b1;
				end
			end
			KIND_PAD: begin
				ev.event_kind = KIND_PAD;
				phase_q = KIND_LATCH;
			end
			default: begin
				// latch the row pair, then step plane and row
				ont = ON_TIME_W'(base_q);
				ev.event_kind = KIND_LATCH;
				ev.row_select = row_q;
				ev.on_time = ont << plane_q;
				phase_q = KIND_PIXEL;
				if (plane_q == PLANE_W'(PLANE_COUNT - 1)) begin
					plane_q = '0;
					if (row_q == ROW_W'(HALF_TILE - 1)) begin
						row_q = '0;
						ev.frame_done = 1'b1;
					end else begin
						row_q = row_q + 1'b1;
					end
				end else begin
					plane_q = plane_q + 1'b1;
				end
			end
		endcase
		expected_events.push_back(ev);
	endfunction

	// channels biased toward the extremes
	function automatic logic [PIXEL_W-1:0] rand_rgb();
		logic [PIXEL_W-1:0] rgb;
		rgb = PIXEL_W'($urandom);
		for (int ch = 0; ch < 3; ch++) begin
			case ($urandom_range(3))
				0: rgb[ch*8 +: 8] = 8'h00;
				1: rgb[ch*8 +: 8] = 8'hFF;
				default: ;
			endcase
		end
		return rgb;
	endfunction

	function automatic void queue_cmd(input logic op, input logic [ADDR_W-1:0] idx,
			input logic [PIXEL_W-1:0] rgb, input bit hold);
		queued_cmd_t q;
		q.cmd.opcode = op;
		q.cmd.pixel_index = idx;
		q.cmd.pixel_rgb = rgb;
		q.hold = hold;
		cmd_queue.push_back(q);
	endfunction

	function automatic void queue_tick(input bit hold);
		queue_cmd(OP_TICK, ADDR_W'($urandom_range(STORE_DEPTH - 1)), PIXEL_W'($urandom),
			hold);
	endfunction

	task automatic apb_write(input logic [APB_ADDR_W-1:0] addr,
			input logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (addr == ADDR_BASE) begin
			base_q = data[BASE_W-1:0];
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
			output logic [APB_DATA_W-1:0] data);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		data = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// wait until all items are taken and every event has come back
	task automatic settle();
		int waited;
		waited = 0;
		while (cmd_queue.size() != 0 || start) begin
			@(posedge clk);
		end
		while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (expected_events.size() != 0) begin
			report_error($sformatf("%0d scan events never arrived", expected_events.size()));
			expected_events.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// item driver
	always @(posedge clk or negedge arst_n) begin : drive
		queued_cmd_t nxt;
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
		end else begin
			if (start && !busy) begin
				model_cmd(request);
			end
			if (!start || !busy) begin
				if (cmd_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct
						&& !(cmd_queue[0].hold && expected_events.size() != 0)) begin
					nxt = cmd_queue.pop_front();
					start <= 1'b1;
					request <= nxt.cmd;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin : monitor
		lmbs_pkg::out_item_t want;
		if (arst_n && result_strobe === 1'b1) begin
			if (expected_events.size() == 0) begin
				report_error($sformatf("unexpected scan event, kind %0d", result.event_kind));
			end else begin
				want = expected_events.pop_front();
				check_field("event_kind", 32'(result.event_kind), 32'(want.event_kind));
				check_field("upper_bits", 32'(result.upper_bits), 32'(want.upper_bits));
				check_field("lower_bits", 32'(result.lower_bits), 32'(want.lower_bits));
				check_field("row_select", 32'(result.row_select), 32'(want.row_select));
				check_field("on_time", 32'(result.on_time), 32'(want.on_time));
				check_field("frame_done", 32'(result.frame_done), 32'(want.frame_done));
			end
			events_checked++;
		end
	end

	initial begin : stimulus
		logic [APB_DATA_W-1:0] readback;
		logic [BASE_W-1:0]     base;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_read(ADDR_BASE, readback);
		check_field("on_time_base after reset", readback,
			32'(lmbs_pkg::ON_TIME_BASE_RESET));

		// every pixel that row pair zero scans is loaded before the first tick
		for (int y = 0; y < FRAME_HEIGHT; y++) begin
			for (int k = 0; k < 4; k++) begin
				queue_cmd(OP_WRITE, ADDR_W'(y * FRAME_WIDTH + SCAN_COLS[k]), rand_rgb(),
					1'b0);
			end
		end

		// pixels read by the first scan steps, plus the store corners
		queue_cmd(OP_WRITE, '0, 24'h000000, 1'b0);
		queue_cmd(OP_WRITE, ADDR_W'(STORE_DEPTH - 1), 24'hFFFFFF, 1'b0);
		queue_cmd(OP_WRITE, ADDR_W'(63 * FRAME_WIDTH), 24'hFFFFFF, 1'b0);
		queue_cmd(OP_WRITE, ADDR_W'(63 * FRAME_WIDTH + HALF_TILE), 24'h000000, 1'b0);
		queue_cmd(OP_WRITE, ADDR_W'(62 * FRAME_WIDTH), 24'hFF0000, 1'b0);
		queue_cmd(OP_WRITE, ADDR_W'(62 * FRAME_WIDTH + HALF_TILE), 24'h00FF00, 1'b0);
		queue_cmd(OP_WRITE, ADDR_W'(61 * FRAME_WIDTH), 24'h0000FF, 1'b0);
		queue_cmd(OP_WRITE, ADDR_W'(61 * FRAME_WIDTH + HALF_TILE), 24'h818181, 1'b0);
		queue_cmd(OP_WRITE, ADDR_W'(60 * FRAME_WIDTH), 24'h010101, 1'b0);
		queue_cmd(OP_WRITE, ADDR_W'(60 * FRAME_WIDTH + HALF_TILE), 24'hFEFEFE, 1'b0);
		repeat (4) queue_tick(1'b0);
		// write right before the tick that reads it
		queue_cmd(OP_WRITE, ADDR_W'(59 * FRAME_WIDTH), 24'hFFFFFF, 1'b0);
		queue_cmd(OP_WRITE, ADDR_W'(59 * FRAME_WIDTH + HALF_TILE), 24'h00FFFF, 1'b0);
		queue_tick(1'b0);
		settle();

		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph)
				0: base = '0;
				1: base = '1;
				3: base = 16'd1;
				default: base = BASE_W'($urandom);
			endcase
			apb_write(ADDR_BASE, {16'($urandom), base});
			// address past the register list is ignored
			apb_write(ADDR_UNMAPPED, $urandom);
			apb_read(ADDR_BASE, readback);
			check_field("on_time_base readback", readback, 32'(base));

			sender_idle_pct = IDLE_PCT[ph];
			for (int t = 0; t < PHASE_TICKS; t++) begin
				if ($urandom_range(19) == 0) begin
					queue_cmd(OP_WRITE, ADDR_W'($urandom_range(STORE_DEPTH - 1)), rand_rgb(),
						1'b0);
				end
				queue_tick((t % HOLD_EVERY) == HOLD_EVERY - 1);
			end
			settle();
		end

		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// File: files.f
sv/lmbs_pkg.sv
sv/lmbs_ram.sv
sv/lmbs_ctrl.sv
sv/lmbs_dpath.sv
sv/led_matrix_bitplane_scanner_top.sv
tb/led_matrix_bitplane_scanner_top_tb.sv
